// File: hw/rtl/cne_pkg.sv
package cne_pkg;

    // Geometry of the seen-ID map
    localparam int MAP_BYTES_DEF = 16;
    localparam int MAP_BYTES_MAX = 16;
    localparam int ID_W          = 7;
    localparam int ID_COUNT      = 128;
    localparam int TIMER_W       = 16;

    // Register reset values
    localparam logic [ID_W-1:0]    START_NODE_ID_RST = 7'd1;
    localparam logic [TIMER_W-1:0] HOLDOFF_TICKS_RST = 16'd200;
    localparam logic [TIMER_W-1:0] WINDOW_TICKS_RST  = 16'd100;

    // Frame decoding and ID limits
    localparam int              RTR_BIT   = 6;
    localparam logic [ID_W-1:0] ID_LIMIT  = 7'd99;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

    // Item kinds carried in op
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_FRAME = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_NODE_ID = 2'd0,
        CFG_HOLDOFF_TICKS = 2'd1,
        CFG_WINDOW_TICKS  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic       op;
        logic [7:0] sid_high;
        logic [7:0] sid_low;
        logic [7:0] length_byte;
    } t_in_item;

    typedef struct packed {
        logic            deliver;
        logic            send_reply;
        logic            send_request;
        logic [ID_W-1:0] node_id;
        logic            id_changed;
        logic            enum_failed;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         index;
        logic [TIMER_W-1:0] wdata;
    } t_cfg_wr;

    // Map update command from the control logic
    typedef struct packed {
        logic            clear;
        logic            record;
        logic [ID_W-1:0] id;
    } t_map_cmd;

    // Lowest unmarked ID in the map
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] id;
    } t_free;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } t_pe8;

    // Lowest set bit of an 8-bit vector
    function automatic t_pe8 pe8(input logic [7:0] v);
        t_pe8 r;
        r.found = |v;
        r.idx   = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                r.idx = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/cne_chan_if.sv
interface cne_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/cne_seen_map.sv
module cne_seen_map #(
    parameter int MAP_BYTES = cne_pkg::MAP_BYTES_DEF
) (
    input  logic             i_clk,
    input  cne_pkg::t_map_cmd i_cmd,
    output cne_pkg::t_free   o_free
);
    localparam int MapBits = MAP_BYTES * 8;
    localparam int Ids     = cne_pkg::ID_COUNT;
    localparam int Bytes   = Ids / 8;

    logic [MapBits-1:0] r_map;
    logic [MapBits-1:0] n_map;
    logic [Ids-1:0]     marked;
    logic [Bytes-1:0]   byte_free;
    logic [2:0]         bit_idx [Bytes];

    // Clear leaves only ID 0 marked; record sets one bit. IDs past the map are dropped.
    for (genvar g = 0; g < MapBits; g++) begin : g_upd
        always_comb begin
            if (i_cmd.clear) begin
                n_map[g] = (g == 0);
            end else begin
                n_map[g] = r_map[g] | (i_cmd.record && (i_cmd.id == cne_pkg::ID_W'(g)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_map <= n_map;
    end

    // IDs beyond the map count as taken
    for (genvar g = 0; g < Ids; g++) begin : g_mark
        if (g < MapBits) begin : g_in
            assign marked[g] = r_map[g];
        end else begin : g_out
            assign marked[g] = 1'b1;
        end
    end

    // First level: lowest free bit inside each byte
    for (genvar k = 0; k < Bytes; k++) begin : g_byte
        cne_pkg::t_pe8 pe;
        assign pe           = cne_pkg::pe8(~marked[8*k +: 8]);
        assign byte_free[k] = pe.found;
        assign bit_idx[k]   = pe.idx;
    end

    // Second level: lowest byte with a free bit, lower half first
    always_comb begin
        cne_pkg::t_pe8 lo_half;
        cne_pkg::t_pe8 hi_half;
        logic [3:0]    byte_sel;
        lo_half  = cne_pkg::pe8(byte_free[7:0]);
        hi_half  = cne_pkg::pe8(byte_free[15:8]);
        byte_sel = lo_half.found ? {1'b0, lo_half.idx} : {1'b1, hi_half.idx};
        o_free.found = lo_half.found | hi_half.found;
        o_free.id    = {byte_sel, bit_idx[byte_sel]};
    end

endmodule

// File: hw/rtl/can_node_id_self_enumeration.sv
// Channel  Dir  Payload                                      Accepted when
// i_in     in   op, sid_high, sid_low, length_byte           valid && ready
// o_out    out  deliver, send_reply, send_request, node_id,  valid && ready
//               id_changed, enum_failed
// i_cfg    in   index, wdata (register write)                valid && ready
//
// An input transaction passes through one input register; then the map search and
// state update feed the result register. One item per cycle is sustained while the
// result is taken; the path is set by the 128-bit lowest-free-ID search over the map.
// Reset is synchronous, active low, and clears control state and registers only.
// A stalled result holds the result register; the input register still takes one
// more item, then input ready drops until the result is taken.
module can_node_id_self_enumeration #(
    parameter int MAP_BYTES = cne_pkg::MAP_BYTES_DEF
) (
    input logic   i_clk,
    input logic   i_rst_n,
    cne_chan_if.sink   i_in,
    cne_chan_if.source o_out,
    cne_chan_if.sink   i_cfg
);
    localparam int IdW = cne_pkg::ID_W;
    localparam int TW  = cne_pkg::TIMER_W;

    // Pipeline registers
    logic                  r_s1_valid;
    cne_pkg::t_in_item     r_s1;
    logic                  r_out_valid;
    cne_pkg::t_out_item    r_out;
    cne_pkg::t_out_item    n_out;

    // Enumeration state
    logic [IdW-1:0] r_cur_id,     n_cur_id;
    logic           r_pending,    n_pending;
    logic           r_collecting, n_collecting;
    logic [TW-1:0]  r_elapsed,    n_elapsed;

    // Configuration registers. There is no start ID register: writes to its index are
    // ignored, and the current ID resets to START_NODE_ID_RST.
    logic [TW-1:0]  r_holdoff;
    logic [TW-1:0]  r_window;

    logic              adv;
    logic              fire;
    cne_pkg::t_map_cmd map_cmd;
    cne_pkg::t_free    free;

    assign adv  = !r_out_valid || o_out.ready;
    assign fire = r_s1_valid && adv;

    assign i_in.ready  = !r_s1_valid || adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    cne_seen_map #(
        .MAP_BYTES(MAP_BYTES)
    ) u_map (
        .i_clk (i_clk),
        .i_cmd (map_cmd),
        .o_free(free)
    );

    // Item processing: next state, map command and result
    always_comb begin
        logic [TW-1:0]  el_inc;
        logic [IdW-1:0] fid;
        el_inc = (r_elapsed != cne_pkg::TIMER_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        fid    = {r_s1.sid_high[3:0], r_s1.sid_low[7:5]};

        n_cur_id     = r_cur_id;
        n_pending    = r_pending;
        n_collecting = r_collecting;
        n_elapsed    = r_elapsed;
        map_cmd      = '0;
        map_cmd.id   = fid;
        n_out        = '0;

        if (fire) begin
            if (r_s1.op == cne_pkg::OP_TICK) begin
                n_elapsed = el_inc;
                if (r_pending && el_inc > r_holdoff) begin
                    // Hold-off over: open the collection window
                    map_cmd.clear      = 1'b1;
                    n_collecting       = 1'b1;
                    n_pending          = 1'b0;
                    n_elapsed          = '0;
                    n_out.send_request = 1'b1;
                end else if (r_collecting && el_inc > r_window) begin
                    // Window over: claim the lowest free ID if in range
                    n_collecting = 1'b0;
                    n_pending    = 1'b0;
                    if (free.found && free.id != '0 && free.id <= cne_pkg::ID_LIMIT) begin
                        n_cur_id         = free.id;
                        n_out.id_changed = 1'b1;
                    end else begin
                        n_out.enum_failed = 1'b1;
                    end
                end
            end else begin
                if (r_collecting) begin
                    map_cmd.record = 1'b1;
                end else if (!r_pending && fid == r_cur_id) begin
                    // Our own ID seen on the bus
                    n_pending = 1'b1;
                    n_elapsed = '0;
                end
                if (r_s1.length_byte[cne_pkg::RTR_BIT]) begin
                    n_out.send_reply = 1'b1;
                    n_elapsed        = '0;
                end else begin
                    n_out.deliver = |r_s1.length_byte[3:0];
                end
            end
        end
        n_out.node_id = n_cur_id;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1 <= i_in.data;
        end
    end

    // Result register and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_cur_id     <= cne_pkg::START_NODE_ID_RST;
            r_pending    <= 1'b0;
            r_collecting <= 1'b0;
            r_elapsed    <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
            r_cur_id     <= n_cur_id;
            r_pending    <= n_pending;
            r_collecting <= n_collecting;
            r_elapsed    <= n_elapsed;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // Configuration writes; only hold-off and window are written, other indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff <= cne_pkg::HOLDOFF_TICKS_RST;
            r_window  <= cne_pkg::WINDOW_TICKS_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.index)
                cne_pkg::CFG_HOLDOFF_TICKS: r_holdoff <= i_cfg.data.wdata;
                cne_pkg::CFG_WINDOW_TICKS:  r_window  <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // Waiting for hold-off and collecting are mutually exclusive phases
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pending && r_collecting))
        else $error("pending and collecting both set");

    // An adopted ID always lies in the allowed range
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.id_changed) |->
            (r_out.node_id != '0 && r_out.node_id <= cne_pkg::ID_LIMIT))
        else $error("adopted ID out of range");

    // Sending the request opens the collection window
    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_out.send_request) |=> r_collecting)
        else $error("request sent without opening the window");

endmodule
